FILE: hw/rtl/i2c_master_byte_engine_assert.svh
// assertion macros for the i2c byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define I2CM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("i2cm check failed");
`define I2CM_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("i2cm check failed");
`else
`define I2CM_ASSERT(label, clk, rst, prop)
`define I2CM_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/i2cm_pkg.sv
// types and constants shared by the i2c byte engine
package i2cm_pkg;
   localparam logic [2:0] MODE_NONE   = 3'd0;
   localparam logic [2:0] MODE_START  = 3'd1;
   localparam logic [2:0] MODE_STOP   = 3'd2;
   localparam logic [2:0] MODE_RSTART = 3'd3;
   localparam logic [2:0] MODE_WRITE  = 3'd4;
   localparam logic [2:0] MODE_READ   = 3'd5;

   localparam logic [1:0] CSR_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_DIVIDER = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT = 2'd2;

   localparam logic        ENABLE_RESET  = 1'b1;
   localparam logic [6:0]  DIVIDER_RESET = 7'd9;
   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

   typedef enum logic [6:0] {
      PH_FREE   = 7'b0000001,
      PH_HELD   = 7'b0000010,
      PH_START  = 7'b0000100,
      PH_STOP   = 7'b0001000,
      PH_RSTART = 7'b0010000,
      PH_WRITE  = 7'b0100000,
      PH_READ   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       scl_in;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic       nack_seen;
      logic [7:0] rx_byte;
      logic       timed_out;
   } rsp_type;
endpackage

FILE: hw/rtl/i2c_master_byte_engine.sv
// i2c master byte engine top level: front classification, queue, bus engine
// Each item is one bus tick: one item is taken per cycle and gives one result,
// which goes through the two-entry input queue, then the result register;
// a result held by rsp_ready stalls the engine, and req_ready drops once the
// queue is full.
// Commands are start, stop, repeated start, write byte and read byte; SCL quarters
// last clock_divider+1 ticks and wait while SCL is stretched low; a command busy for
// timeout_limit ticks aborts with timed_out set. Reset gives enable 1, divider 9,
// timeout 10000.
module i2c_master_byte_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   logic        enable_ff;
   logic [6:0]  divider_ff;
   logic [15:0] timeout_ff, tlimit;
   logic        q_valid, q_ready;
   i2cm_pkg::req_type q_data, front_data;
   logic [$bits(i2cm_pkg::req_type)-1:0] q_raw;

   assign csr_ready = 1'b1;
   assign tlimit = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;

   // out-of-range modes are dropped to none up front
   always_comb begin
      front_data = req_data;
      if (req_data.mode > i2cm_pkg::MODE_READ) front_data.mode = i2cm_pkg::MODE_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= i2cm_pkg::ENABLE_RESET;
         divider_ff <= i2cm_pkg::DIVIDER_RESET;
         timeout_ff <= i2cm_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            i2cm_pkg::CSR_ENABLE:  enable_ff  <= csr_data[0];
            i2cm_pkg::CSR_DIVIDER: divider_ff <= csr_data[6:0];
            i2cm_pkg::CSR_TIMEOUT: timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   i2cm_queue #(.Width($bits(i2cm_pkg::req_type))) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(front_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_raw)
   );
   assign q_data = i2cm_pkg::req_type'(q_raw);

   i2cm_back u_back (
      .clock(clock), .reset(reset),
      .tick_valid(q_valid), .tick_ready(q_ready), .tick_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .enable(enable_ff), .clock_divider(divider_ff), .timeout_limit(tlimit)
   );
endmodule

FILE: hw/rtl/i2cm_queue.sv
// two-entry item queue between the front and back parts
module i2cm_queue #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);
   logic [Width-1:0] slot_ff [2];
   logic [Width-1:0] slot_in [2];
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[0];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot_in[0] = in_data;
         end else begin
            slot_in[1] = in_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

`include "i2c_master_byte_engine_assert.svh"
   `I2CM_ASSERT(a_no_overflow, clock, reset, (count_ff == 2'd2) |-> !push)
   `I2CM_ASSERT(a_count_step, clock, reset, push && !pop |=> count_ff == $past(count_ff) + 2'd1)
   `I2CM_ASSERT_NORST(a_reset_empty, clock, reset |=> count_ff == 2'd0)
endmodule

FILE: hw/rtl/i2cm_back.sv
// bus engine: one tick per item, phase, quarter, shift and timeout logic
module i2cm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             tick_valid,
   output logic             tick_ready,
   input  i2cm_pkg::req_type tick_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output i2cm_pkg::rsp_type rsp_data,
   input  logic             enable,
   input  logic [6:0]       clock_divider,
   input  logic [15:0]      timeout_limit
);
   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [6:0]  div_ff, div_in;
   logic [1:0]  quarter_ff, quarter_in;
   logic [15:0] tcount_ff, tcount_in;
   logic        ack_ff, ack_in;
   logic [7:0]  received_ff, received_in;
   logic        nack_choice_ff, nack_choice_in;
   logic        tflag_ff, tflag_in;
   logic        done;
   logic        scl_now, sda_now, scl_new, sda_new;
   logic        busy_now, busy_new, held, step;
   logic        out_valid_ff;
   i2cm_pkg::rsp_type out_ff, out_in;

   function automatic logic [1:0] drive_f(i2cm_pkg::phase_type ph, logic [1:0] q,
                                          logic [3:0] bc, logic sb, logic nc);
      logic scl, sda;
      scl = 1'b0;
      sda = 1'b0;
      unique case (ph)
         i2cm_pkg::PH_HELD: scl = 1'b1;
         i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
            scl = (q == 2'd3) || (q == 2'd0 && ph == i2cm_pkg::PH_RSTART);
            sda = q[1];
         end
         i2cm_pkg::PH_STOP: begin
            scl = (q == 2'd0);
            sda = (q != 2'd3);
         end
         i2cm_pkg::PH_WRITE: begin
            scl = !q[1];
            sda = bc[3] ? 1'b0 : !sb;
         end
         i2cm_pkg::PH_READ: begin
            scl = !q[1];
            sda = bc[3] ? !nc : 1'b0;
         end
         default: ;
      endcase
      return {scl, sda};
   endfunction

   function automatic logic busy_f(i2cm_pkg::phase_type ph);
      return !(ph == i2cm_pkg::PH_FREE || ph == i2cm_pkg::PH_HELD);
   endfunction

   assign step       = tick_valid && tick_ready;
   assign tick_ready = !out_valid_ff || rsp_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_ff;
   assign {scl_now, sda_now} = drive_f(phase_ff, quarter_ff, bit_count_ff, shift_ff[7],
                                       nack_choice_ff);
   assign busy_now = busy_f(phase_ff);
   assign held     = (phase_ff == i2cm_pkg::PH_HELD);

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      div_in         = div_ff;
      quarter_in     = quarter_ff;
      tcount_in      = tcount_ff;
      ack_in         = ack_ff;
      received_in    = received_ff;
      nack_choice_in = nack_choice_ff;
      tflag_in       = tflag_ff;
      done           = 1'b0;
      if (!enable) begin
         phase_in = i2cm_pkg::PH_FREE;
         bit_count_in = 4'd0; div_in = 7'd0; quarter_in = 2'd0; tcount_in = 16'd0;
      end else if (!busy_now) begin
         if (tick_data.mode == i2cm_pkg::MODE_START || tick_data.mode == i2cm_pkg::MODE_RSTART
             || (held && (tick_data.mode == i2cm_pkg::MODE_STOP
             || tick_data.mode == i2cm_pkg::MODE_WRITE
             || tick_data.mode == i2cm_pkg::MODE_READ))) begin
            bit_count_in = 4'd0; div_in = 7'd0; quarter_in = 2'd0; tcount_in = 16'd0;
            tflag_in = 1'b0;
            priority case (tick_data.mode)
               i2cm_pkg::MODE_STOP:  phase_in = i2cm_pkg::PH_STOP;
               i2cm_pkg::MODE_WRITE: begin
                  phase_in = i2cm_pkg::PH_WRITE;
                  shift_in = tick_data.tx_byte;
               end
               i2cm_pkg::MODE_READ: begin
                  phase_in = i2cm_pkg::PH_READ;
                  shift_in = 8'd0;
                  nack_choice_in = tick_data.send_nack;
               end
               default: phase_in = held ? i2cm_pkg::PH_RSTART : i2cm_pkg::PH_START;
            endcase
         end
      end else begin
         if (!scl_now && !tick_data.scl_in) begin
            // stretched clock: hold the quarter
         end else if (div_ff >= clock_divider) begin
            div_in = 7'd0;
            if (quarter_ff == 2'd2) begin
               if (phase_ff == i2cm_pkg::PH_WRITE && bit_count_ff[3]) begin
                  ack_in = tick_data.sda_in;
               end
               if (phase_ff == i2cm_pkg::PH_READ && !bit_count_ff[3]) begin
                  shift_in = {shift_ff[6:0], tick_data.sda_in};
                  if (bit_count_ff == 4'd7) begin
                     received_in = {shift_ff[6:0], tick_data.sda_in};
                  end
               end
            end
            if (quarter_ff != 2'd3) begin
               quarter_in = quarter_ff + 2'd1;
            end else begin
               quarter_in = 2'd0;
               priority if (phase_ff == i2cm_pkg::PH_START || phase_ff == i2cm_pkg::PH_RSTART) begin
                  phase_in = i2cm_pkg::PH_HELD; done = 1'b1;
               end else if (phase_ff == i2cm_pkg::PH_STOP) begin
                  phase_in = i2cm_pkg::PH_FREE; done = 1'b1;
               end else if (bit_count_ff[3]) begin
                  phase_in = i2cm_pkg::PH_HELD; bit_count_in = 4'd0; done = 1'b1;
               end else begin
                  if (phase_ff == i2cm_pkg::PH_WRITE) shift_in = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
               end
            end
         end else begin
            div_in = div_ff + 7'd1;
         end
         if (busy_f(phase_in)) begin
            tcount_in = tcount_ff + 16'd1;
            if (tcount_in >= timeout_limit) begin
               if (phase_in == i2cm_pkg::PH_WRITE) ack_in = 1'b1;
               if (phase_in == i2cm_pkg::PH_READ && !bit_count_in[3]) received_in = 8'd0;
               phase_in = i2cm_pkg::PH_FREE;
               bit_count_in = 4'd0; div_in = 7'd0; quarter_in = 2'd0; tcount_in = 16'd0;
               tflag_in = 1'b1; done = 1'b1;
            end
         end else begin
            bit_count_in = 4'd0; div_in = 7'd0; quarter_in = 2'd0; tcount_in = 16'd0;
         end
      end
   end

   assign {scl_new, sda_new} = drive_f(phase_in, quarter_in, bit_count_in, shift_in[7],
                                       nack_choice_in);
   assign busy_new = busy_f(phase_in);

   always_comb begin
      out_in.scl_low   = scl_new;
      out_in.sda_low   = sda_new;
      out_in.busy_res  = busy_new;
      out_in.done_res  = done;
      out_in.nack_seen = ack_in;
      out_in.rx_byte   = received_in;
      out_in.timed_out = tflag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_FREE;
         bit_count_ff <= 4'd0; shift_ff <= 8'd0; div_ff <= 7'd0; quarter_ff <= 2'd0;
         tcount_ff <= 16'd0; ack_ff <= 1'b0; received_ff <= 8'd0;
         nack_choice_ff <= 1'b0; tflag_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            bit_count_ff <= bit_count_in; shift_ff <= shift_in; div_ff <= div_in;
            quarter_ff <= quarter_in; tcount_ff <= tcount_in; ack_ff <= ack_in;
            received_ff <= received_in; nack_choice_ff <= nack_choice_in;
            tflag_ff <= tflag_in;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (step) out_ff <= out_in;
   end

`include "i2c_master_byte_engine_assert.svh"
   `I2CM_ASSERT(a_phase_onehot, clock, reset, $onehot(phase_ff))
   `I2CM_ASSERT(a_free_counters, clock, reset, !busy_now |-> tcount_ff == 16'd0)
   `I2CM_ASSERT(a_bitcount_range, clock, reset, bit_count_ff <= 4'd8)
   `I2CM_ASSERT(a_free_released, clock, reset, (phase_ff == i2cm_pkg::PH_FREE) |-> !scl_now && !sda_now)
endmodule
